>>> sv/pza_pkg.sv
// pza_pkg: shared types and constants for the proximity zone alert block.
// Holds field widths, fixed-point scale factors, register and zone codes
// and the structs passed between the pipeline stages. No dependencies.
package pza_pkg;

    localparam int RING_DEPTH = 5;

    localparam int ECHO_W     = 15;
    localparam int DIST_W     = 9;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ZONE_W     = 2;

    localparam logic [DIST_W-1:0] RANGE_MAX = DIST_W'(400);

    // floor(echo * 343 / 20000) as (echo * ECHO_MULT) >> ECHO_SHIFT,
    // exact for every 15-bit echo time
    localparam int ECHO_MULT_W = 25;
    localparam int ECHO_SHIFT  = 30;
    localparam int ECHO_PROD_W = ECHO_W + ECHO_MULT_W;
    localparam int ECHO_Q_W    = ECHO_PROD_W - ECHO_SHIFT;
    localparam logic [ECHO_MULT_W-1:0] ECHO_MULT = ECHO_MULT_W'(18414673);

    localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int TOTAL_W = $clog2(RING_DEPTH * 400 + 1);

    // floor(total / RING_DEPTH) as (total * AVG_MULT) >> AVG_SHIFT
    localparam int AVG_SHIFT  = TOTAL_W + $clog2(RING_DEPTH);
    localparam int AVG_MULT_W = AVG_SHIFT + 1;
    localparam int AVG_PROD_W = TOTAL_W + AVG_MULT_W;
    localparam logic [AVG_MULT_W-1:0] AVG_MULT =
        AVG_MULT_W'(((1 << AVG_SHIFT) + RING_DEPTH - 1) / RING_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_INTERVAL = CFG_IDX_W'(3);

    localparam logic [DIST_W-1:0]     NEAR_LIMIT_RST      = DIST_W'(50);
    localparam logic [DIST_W-1:0]     FAR_LIMIT_RST       = DIST_W'(250);
    localparam logic [CFG_DATA_W-1:0] BLINK_PERIOD_RST    = CFG_DATA_W'(500);
    localparam logic [CFG_DATA_W-1:0] DETECT_INTERVAL_RST = CFG_DATA_W'(1000);

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ECHO = 1'b1;

    localparam logic [ZONE_W-1:0] ZONE_NONE  = ZONE_W'(0);
    localparam logic [ZONE_W-1:0] ZONE_RED   = ZONE_W'(1);
    localparam logic [ZONE_W-1:0] ZONE_GREEN = ZONE_W'(2);

    typedef struct packed {
        logic [DIST_W-1:0]     near_limit;
        logic [DIST_W-1:0]     far_limit;
        logic [CFG_DATA_W-1:0] blink_period;
        logic [CFG_DATA_W-1:0] detect_interval;
    } t_cfg;

    typedef struct packed {
        logic              func;
        logic [DIST_W-1:0] dist_cm;
    } t_range_item;

    typedef struct packed {
        logic               func;
        logic [TOTAL_W-1:0] total;
        logic               blink_phase;
        logic               request;
    } t_ring_item;

    typedef struct packed {
        logic              red_led;
        logic              green_led;
        logic              measure_request;
        logic [DIST_W-1:0] mean_distance;
        logic [ZONE_W-1:0] zone;
    } t_result;

endpackage

>>> sv/pza_in_if.sv
// pza_in_if: valid/ready channel carrying one input item.
// Depends on pza_pkg for field widths.
interface pza_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [pza_pkg::ECHO_W-1:0] echo_time;

    modport source (output valid, output func, output echo_time, input ready);
    modport sink   (input valid, input func, input echo_time, output ready);
endinterface

>>> sv/pza_out_if.sv
// pza_out_if: valid/ready channel carrying one result item.
// Depends on pza_pkg for field widths.
interface pza_out_if;
    logic                       valid;
    logic                       ready;
    logic                       red_led;
    logic                       green_led;
    logic                       measure_request;
    logic [pza_pkg::DIST_W-1:0] mean_distance;
    logic [pza_pkg::ZONE_W-1:0] zone;

    modport source (output valid, output red_led, output green_led,
                    output measure_request, output mean_distance, output zone,
                    input ready);
    modport sink   (input valid, input red_led, input green_led,
                    input measure_request, input mean_distance, input zone,
                    output ready);
endinterface

>>> sv/proximity_zone_alert.sv
// proximity_zone_alert: top level of the ultrasonic range alert.
// Depends on pza_pkg, pza_in_if, pza_out_if and the pza_* stage modules.
//
// Takes one item per clock while input ready is high: a millisecond tick or
// an echo time. Each transfer in gives exactly one result: the transfer
// loads the range stage, then the ring stage, then the zone logic loads the
// output register, where the result's valid rises. The stages advance
// together and a two-entry output register holds finished results, so input
// ready stays high while the sink keeps up and drops only when two results
// are waiting.
// Configuration registers are written through the plain write port and must
// be changed only with no transfers in flight.
module proximity_zone_alert (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pza_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pza_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pza_in_if.sink                         i_in,
    pza_out_if.source                      o_out
);
    pza_pkg::t_cfg        r_cfg;
    logic                 adv;
    logic                 range_valid;
    pza_pkg::t_range_item range_item;
    logic                 ring_valid;
    pza_pkg::t_ring_item  ring_item;
    pza_pkg::t_result     zone_result;
    pza_pkg::t_result     out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit      <= pza_pkg::NEAR_LIMIT_RST;
            r_cfg.far_limit       <= pza_pkg::FAR_LIMIT_RST;
            r_cfg.blink_period    <= pza_pkg::BLINK_PERIOD_RST;
            r_cfg.detect_interval <= pza_pkg::DETECT_INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pza_pkg::CFG_NEAR_LIMIT: begin
                    r_cfg.near_limit <= i_cfg_data[pza_pkg::DIST_W-1:0];
                end
                pza_pkg::CFG_FAR_LIMIT: begin
                    r_cfg.far_limit <= i_cfg_data[pza_pkg::DIST_W-1:0];
                end
                pza_pkg::CFG_BLINK_PERIOD: begin
                    r_cfg.blink_period <= i_cfg_data;
                end
                pza_pkg::CFG_DETECT_INTERVAL: begin
                    r_cfg.detect_interval <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = adv;

    pza_range_stage u_range (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_valid     (i_in.valid),
        .i_func      (i_in.func),
        .i_echo_time (i_in.echo_time),
        .o_valid     (range_valid),
        .o_item      (range_item)
    );

    pza_ring_stage u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (r_cfg),
        .i_valid (range_valid),
        .i_item  (range_item),
        .o_valid (ring_valid),
        .o_item  (ring_item)
    );

    pza_zone_stage u_zone (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_cfg    (r_cfg),
        .i_valid  (ring_valid),
        .i_item   (ring_item),
        .o_result (zone_result)
    );

    pza_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (adv && ring_valid),
        .i_result (zone_result),
        .i_ready  (o_out.ready),
        .o_valid  (o_out.valid),
        .o_result (out_result),
        .o_adv    (adv)
    );

    assign o_out.red_led         = out_result.red_led;
    assign o_out.green_led       = out_result.green_led;
    assign o_out.measure_request = out_result.measure_request;
    assign o_out.mean_distance   = out_result.mean_distance;
    assign o_out.zone            = out_result.zone;
endmodule

>>> sv/pza_range_stage.sv
// pza_range_stage: input register stage; converts echo time to a clamped
// distance in cm. Depends on pza_pkg.
module pza_range_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_valid,
    input  logic                       i_func,
    input  logic [pza_pkg::ECHO_W-1:0] i_echo_time,
    output logic                       o_valid,
    output pza_pkg::t_range_item       o_item
);
    logic [pza_pkg::ECHO_PROD_W-1:0] prod;
    logic [pza_pkg::ECHO_Q_W-1:0]    quot;
    logic [pza_pkg::DIST_W-1:0]      n_dist;
    logic                            r_valid;
    pza_pkg::t_range_item            r_item;

    assign prod = pza_pkg::ECHO_PROD_W'(i_echo_time) *
                  pza_pkg::ECHO_PROD_W'(pza_pkg::ECHO_MULT);
    assign quot = prod[pza_pkg::ECHO_PROD_W-1:pza_pkg::ECHO_SHIFT];

    always_comb begin
        if (quot == '0 || quot > pza_pkg::ECHO_Q_W'(pza_pkg::RANGE_MAX)) begin
            n_dist = pza_pkg::RANGE_MAX;
        end else begin
            n_dist = quot[pza_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
        if (i_adv) begin
            r_item.func    <= i_func;
            r_item.dist_cm <= n_dist;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

>>> sv/pza_ring_stage.sv
// pza_ring_stage: sample ring with running total, blink and detection
// tick counters. Depends on pza_pkg.
module pza_ring_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  pza_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  pza_pkg::t_range_item i_item,
    output logic                 o_valid,
    output pza_pkg::t_ring_item  o_item
);
    logic [pza_pkg::DIST_W-1:0]     r_ring [pza_pkg::RING_DEPTH];
    logic [pza_pkg::PTR_W-1:0]      r_ptr;
    logic [pza_pkg::TOTAL_W-1:0]    r_total;
    logic [pza_pkg::CFG_DATA_W-1:0] r_blink_cnt;
    logic [pza_pkg::CFG_DATA_W-1:0] r_detect_cnt;
    logic                           r_blink_phase;
    logic                           r_valid;
    pza_pkg::t_ring_item            r_item;

    logic [pza_pkg::TOTAL_W-1:0]    n_total;
    logic [pza_pkg::PTR_W-1:0]      n_ptr;
    logic [pza_pkg::CFG_DATA_W:0]   blink_inc;
    logic [pza_pkg::CFG_DATA_W:0]   detect_inc;
    logic                           blink_hit;
    logic                           detect_hit;
    logic                           take_echo;
    logic                           take_tick;

    assign take_echo = i_adv && i_valid && (i_item.func == pza_pkg::FUNC_ECHO);
    assign take_tick = i_adv && i_valid && (i_item.func == pza_pkg::FUNC_TICK);

    assign n_total = r_total - pza_pkg::TOTAL_W'(r_ring[r_ptr])
                   + pza_pkg::TOTAL_W'(i_item.dist_cm);
    assign n_ptr   = (r_ptr == pza_pkg::PTR_W'(pza_pkg::RING_DEPTH - 1)) ?
                     '0 : r_ptr + pza_pkg::PTR_W'(1);

    assign blink_inc  = {1'b0, r_blink_cnt} + 1'b1;
    assign detect_inc = {1'b0, r_detect_cnt} + 1'b1;
    assign blink_hit  = blink_inc >= {1'b0, i_cfg.blink_period};
    assign detect_hit = detect_inc >= {1'b0, i_cfg.detect_interval};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < pza_pkg::RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_ptr         <= '0;
            r_total       <= '0;
            r_blink_cnt   <= '0;
            r_detect_cnt  <= '0;
            r_blink_phase <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            if (i_adv) begin
                r_valid <= i_valid;
            end
            if (take_echo) begin
                r_ring[r_ptr] <= i_item.dist_cm;
                r_ptr         <= n_ptr;
                r_total       <= n_total;
            end
            if (take_tick) begin
                if (blink_hit) begin
                    r_blink_phase <= !r_blink_phase;
                    r_blink_cnt   <= '0;
                end else begin
                    r_blink_cnt   <= blink_inc[pza_pkg::CFG_DATA_W-1:0];
                end
                if (detect_hit) begin
                    r_detect_cnt <= '0;
                end else begin
                    r_detect_cnt <= detect_inc[pza_pkg::CFG_DATA_W-1:0];
                end
            end
        end
    end

    // payload follows the updated state of the same transfer
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item.func <= i_item.func;
            r_item.total <= take_echo ? n_total : r_total;
            r_item.blink_phase <= (take_tick && blink_hit) ? !r_blink_phase
                                                           : r_blink_phase;
            r_item.request <= take_tick && detect_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

>>> sv/pza_zone_stage.sv
// pza_zone_stage: ring average, zone flags and LED drive. Produces the
// result item for the output buffer. Depends on pza_pkg.
module pza_zone_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  pza_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  pza_pkg::t_ring_item i_item,
    output pza_pkg::t_result    o_result
);
    logic [pza_pkg::DIST_W-1:0]     r_avg;
    logic                           r_red;
    logic                           r_green;

    logic [pza_pkg::AVG_PROD_W-1:0] prod;
    logic [pza_pkg::DIST_W-1:0]     new_avg;
    logic                           new_red;
    logic                           new_green;
    logic                           is_echo;
    logic [pza_pkg::DIST_W-1:0]     avg;
    logic                           red;
    logic                           green;
    logic [pza_pkg::ZONE_W-1:0]     zone;

    assign prod = pza_pkg::AVG_PROD_W'(i_item.total) *
                  pza_pkg::AVG_PROD_W'(pza_pkg::AVG_MULT);
    assign new_avg = prod[pza_pkg::AVG_SHIFT +: pza_pkg::DIST_W];

    assign new_red   = (new_avg < i_cfg.near_limit) && (new_avg != '0);
    assign new_green = (new_avg >= i_cfg.near_limit) && (new_avg < i_cfg.far_limit);

    assign is_echo = (i_item.func == pza_pkg::FUNC_ECHO);
    assign avg     = is_echo ? new_avg   : r_avg;
    assign red     = is_echo ? new_red   : r_red;
    assign green   = is_echo ? new_green : r_green;

    always_comb begin
        if (red) begin
            zone = pza_pkg::ZONE_RED;
        end else if (green) begin
            zone = pza_pkg::ZONE_GREEN;
        end else begin
            zone = pza_pkg::ZONE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg   <= '0;
            r_red   <= 1'b0;
            r_green <= 1'b0;
        end else if (i_adv && i_valid && is_echo) begin
            r_avg   <= new_avg;
            r_red   <= new_red;
            r_green <= new_green;
        end
    end

    assign o_result.red_led         = (zone == pza_pkg::ZONE_RED) && i_item.blink_phase;
    assign o_result.green_led       = (zone == pza_pkg::ZONE_GREEN) && i_item.blink_phase;
    assign o_result.measure_request = i_item.request;
    assign o_result.mean_distance   = avg;
    assign o_result.zone            = zone;
endmodule

>>> sv/pza_out_buf.sv
// pza_out_buf: two-entry output register with skid entry. Drives the
// pipeline advance. Depends on pza_pkg.
module pza_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pza_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output pza_pkg::t_result o_result,
    output logic             o_adv
);
    logic             r_main_v;
    logic             r_skid_v;
    pza_pkg::t_result r_main;
    pza_pkg::t_result r_skid;

    logic             n_main_v;
    logic             n_skid_v;
    pza_pkg::t_result n_main;
    pza_pkg::t_result n_skid;
    logic             pop;

    assign pop = r_main_v && i_ready;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (pop) begin
            n_main   = r_skid;
            n_main_v = r_skid_v;
            n_skid_v = 1'b0;
        end
        if (i_push) begin
            if (!n_main_v) begin
                n_main   = i_result;
                n_main_v = 1'b1;
            end else begin
                n_skid   = i_result;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_valid  = r_main_v;
    assign o_result = r_main;
    assign o_adv    = !r_skid_v;
endmodule

>>> verif/testbench.sv
// testbench: self-checking bench for proximity_zone_alert, predicting every result
// from its own copy of the ring average, zone and tick counter logic.
// Depends on pza_pkg, pza_in_if, pza_out_if and the proximity_zone_alert RTL.
module testbench;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_WAIT     = 18;
    localparam int HOLD_CYCLES  = 150;
    localparam int PRINT_CAP    = 40;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [pza_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pza_pkg::CFG_DATA_W-1:0] cfg_data;

    pza_in_if  in_ch ();
    pza_out_if out_ch ();

    proximity_zone_alert i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state and register copies
    logic [pza_pkg::DIST_W-1:0]     near_lim;
    logic [pza_pkg::DIST_W-1:0]     far_lim;
    logic [pza_pkg::CFG_DATA_W-1:0] blink_len;
    logic [pza_pkg::CFG_DATA_W-1:0] detect_len;
    logic [pza_pkg::DIST_W-1:0]     dist_ring [pza_pkg::RING_DEPTH];
    int                             ring_slot;
    int                             ring_sum;
    logic [pza_pkg::DIST_W-1:0]     avg_dist;
    logic                           red_on;
    logic                           green_on;
    logic                           blink_on;
    int                             blink_ticks;
    int                             detect_ticks;

    pza_pkg::t_result alerts_due [$];
    int               err_count = 0;
    bit               tx_gaps   = 1'b0;
    bit               rx_stalls = 1'b0;
    int               hold_off  = 0;
    int               quiet     = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_model();
        near_lim     = pza_pkg::NEAR_LIMIT_RST;
        far_lim      = pza_pkg::FAR_LIMIT_RST;
        blink_len    = pza_pkg::BLINK_PERIOD_RST;
        detect_len   = pza_pkg::DETECT_INTERVAL_RST;
        foreach (dist_ring[k]) dist_ring[k] = '0;
        ring_slot    = 0;
        ring_sum     = 0;
        avg_dist     = '0;
        red_on       = 1'b0;
        green_on     = 1'b0;
        blink_on     = 1'b0;
        blink_ticks  = 0;
        detect_ticks = 0;
    endfunction

    function automatic pza_pkg::t_result predict_alert(
        logic func, logic [pza_pkg::ECHO_W-1:0] echo);
        pza_pkg::t_result           r;
        int                         d;
        logic [pza_pkg::ZONE_W-1:0] z;
        r = '0;
        if (func == pza_pkg::FUNC_TICK) begin
            if (blink_ticks + 1 >= int'(blink_len)) begin
                blink_on    = !blink_on;
                blink_ticks = 0;
            end else begin
                blink_ticks++;
            end
            if (detect_ticks + 1 >= int'(detect_len)) begin
                r.measure_request = 1'b1;
                detect_ticks      = 0;
            end else begin
                detect_ticks++;
            end
        end else begin
            d = (int'(echo) * 343) / 20000;
            if (d == 0 || d > 400) begin
                d = 400;
            end
            ring_sum             = ring_sum - int'(dist_ring[ring_slot]) + d;
            dist_ring[ring_slot] = pza_pkg::DIST_W'(d);
            ring_slot            = (ring_slot + 1) % pza_pkg::RING_DEPTH;
            avg_dist             = pza_pkg::DIST_W'(ring_sum / pza_pkg::RING_DEPTH);
            red_on               = (avg_dist < near_lim) && (avg_dist != '0);
            green_on             = (avg_dist >= near_lim) && (avg_dist < far_lim);
        end
        z = red_on ? pza_pkg::ZONE_RED : (green_on ? pza_pkg::ZONE_GREEN : pza_pkg::ZONE_NONE);
        r.red_led       = (z == pza_pkg::ZONE_RED) && blink_on;
        r.green_led     = (z == pza_pkg::ZONE_GREEN) && blink_on;
        r.mean_distance = avg_dist;
        r.zone          = z;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        err_count++;
        if (err_count <= PRINT_CAP) begin
            $display("%0t: mismatch on %s, got %0d, expected %0d", $time, field, got, want);
        end
    endtask

    // one item per call; valid is left high so the next call can follow back to back
    task automatic send_item(input logic func, input logic [pza_pkg::ECHO_W-1:0] echo);
        int gap;
        gap = tx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= func;
        in_ch.echo_time <= echo;
        do @(posedge i_clk); while (!in_ch.ready);
        alerts_due.push_back(predict_alert(func, echo));
    endtask

    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (alerts_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int near, input int far, input int blink, input int detect);
        cfg_we   <= 1'b1;
        cfg_idx  <= pza_pkg::CFG_NEAR_LIMIT;
        cfg_data <= pza_pkg::CFG_DATA_W'(near);
        @(posedge i_clk);
        cfg_idx  <= pza_pkg::CFG_FAR_LIMIT;
        cfg_data <= pza_pkg::CFG_DATA_W'(far);
        @(posedge i_clk);
        cfg_idx  <= pza_pkg::CFG_BLINK_PERIOD;
        cfg_data <= pza_pkg::CFG_DATA_W'(blink);
        @(posedge i_clk);
        cfg_idx  <= pza_pkg::CFG_DETECT_INTERVAL;
        cfg_data <= pza_pkg::CFG_DATA_W'(detect);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        near_lim   = pza_pkg::DIST_W'(near);
        far_lim    = pza_pkg::DIST_W'(far);
        blink_len  = pza_pkg::CFG_DATA_W'(blink);
        detect_len = pza_pkg::CFG_DATA_W'(detect);
    endtask

    // output side: random stalls, a long hold-off on request, field-by-field check
    initial begin : result_checker
        int               stall;
        pza_pkg::t_result want;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = rx_stalls ? $urandom_range(0, MAX_WAIT) : 0;
            if (hold_off > 0) begin
                stall    = hold_off;
                hold_off = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            if (alerts_due.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = alerts_due.pop_front();
                if (out_ch.red_led !== want.red_led)
                    report_mismatch("red_led", out_ch.red_led, want.red_led);
                if (out_ch.green_led !== want.green_led)
                    report_mismatch("green_led", out_ch.green_led, want.green_led);
                if (out_ch.measure_request !== want.measure_request)
                    report_mismatch("measure_request", out_ch.measure_request,
                                    want.measure_request);
                if (out_ch.mean_distance !== want.mean_distance)
                    report_mismatch("mean_distance", out_ch.mean_distance,
                                    want.mean_distance);
                if (out_ch.zone !== want.zone)
                    report_mismatch("zone", out_ch.zone, want.zone);
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // empty ring: zero average, then the first reading
    task automatic test_reset_state();
        send_item(pza_pkg::FUNC_TICK, '0);
        send_item(pza_pkg::FUNC_ECHO, '0);
        settle_block();
    endtask

    // timeouts, field maximum, zero and over-range distances, the 400 cm edge
    task automatic test_echo_range();
        configure(pza_pkg::NEAR_LIMIT_RST, pza_pkg::FAR_LIMIT_RST, 1, 1);
        send_item(pza_pkg::FUNC_ECHO, 15'd32767);
        send_item(pza_pkg::FUNC_ECHO, 15'd30000);
        send_item(pza_pkg::FUNC_ECHO, 15'd58);
        send_item(pza_pkg::FUNC_ECHO, 15'd59);
        send_item(pza_pkg::FUNC_ECHO, 15'd23323);
        send_item(pza_pkg::FUNC_ECHO, 15'd23324);
        send_item(pza_pkg::FUNC_ECHO, 15'd23382);
        send_item(pza_pkg::FUNC_TICK, 15'h7FFF);
        settle_block();
    endtask

    // limit extremes, including near above far
    task automatic test_zone_select();
        configure(511, 511, 1, 3);
        send_item(pza_pkg::FUNC_ECHO, 15'd2916);
        send_item(pza_pkg::FUNC_TICK, '0);
        settle_block();
        configure(0, 0, 1, 3);
        send_item(pza_pkg::FUNC_ECHO, 15'd2916);
        send_item(pza_pkg::FUNC_TICK, '0);
        settle_block();
        configure(0, 511, 1, 3);
        send_item(pza_pkg::FUNC_ECHO, 15'd2916);
        send_item(pza_pkg::FUNC_TICK, '0);
        settle_block();
        configure(300, 100, 1, 3);
        send_item(pza_pkg::FUNC_ECHO, 15'd2916);
        send_item(pza_pkg::FUNC_TICK, '0);
        settle_block();
    endtask

    // zero period fires every tick; widest period never fires here
    task automatic test_tick_counters();
        configure(pza_pkg::NEAR_LIMIT_RST, pza_pkg::FAR_LIMIT_RST, 0, 0);
        repeat (3) send_item(pza_pkg::FUNC_TICK, '0);
        settle_block();
        configure(pza_pkg::NEAR_LIMIT_RST, pza_pkg::FAR_LIMIT_RST, 65535, 65535);
        repeat (2) send_item(pza_pkg::FUNC_TICK, '0);
        settle_block();
    endtask

    task automatic random_item(inout int aim_echo, input int seq);
        int kind;
        int echo;
        if (seq % 8 == 0) begin
            aim_echo = ($urandom_range(1, 420) * 20000) / 343;
        end
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            send_item(pza_pkg::FUNC_TICK, pza_pkg::ECHO_W'($urandom_range(0, 32767)));
        end else if (kind < 90) begin
            echo = aim_echo + $urandom_range(0, 120);
            if (echo > 32767) echo = 32767;
            send_item(pza_pkg::FUNC_ECHO, pza_pkg::ECHO_W'(echo));
        end else begin
            send_item(pza_pkg::FUNC_ECHO, pza_pkg::ECHO_W'($urandom_range(0, 32767)));
        end
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        int aim_echo;
        aim_echo  = 3000;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_off  = HOLD_CYCLES;
        for (int k = 0; k < 40; k++) random_item(aim_echo, k);
        settle_block();
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        int near;
        int far;
        int mode;
        int aim_echo;
        aim_echo = 3000;
        for (int p = 0; p < phases; p++) begin
            settle_block();
            near = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(10, 200);
            far  = near + $urandom_range(0, 250);
            if (far > 511) far = 511;
            configure(near, far,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 25),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 25));
            mode      = $urandom_range(0, 3);
            tx_gaps   = mode[0];
            rx_stalls = mode[1];
            for (int k = 0; k < per_phase; k++) random_item(aim_echo, k);
        end
        settle_block();
    endtask

    initial begin : sequencer
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= pza_pkg::CFG_NEAR_LIMIT;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.func      <= pza_pkg::FUNC_TICK;
        in_ch.echo_time <= '0;
        clear_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_echo_range();
        test_zone_select();
        test_tick_counters();
        test_output_backpressure();
        test_random_traffic(14, 100);

        settle_block();
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
